@@ hdl/stereo_db_gain_saturate_macros.svh @@
// Assertion helpers used by the block's top-level module.
`ifndef STEREO_DB_GAIN_SATURATE_MACROS_SVH
`define STEREO_DB_GAIN_SATURATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDGS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sdgs_pkg.sv @@
package sdgs_pkg;

    // Sample and gain formats
    localparam int SAMPLE_W       = 16;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int FACTOR_W       = GAIN_FRAC_BITS + 2;
    localparam int GAIN_W         = 12;
    localparam int GAIN_MIN       = -1200;
    localparam int GAIN_MAX       = 100;

    // Table geometry: 200 steps of 0.1 dB per decade of gain
    localparam int STEPS   = 200;
    localparam int DECADES = 7;
    localparam int IDX_W   = $clog2(GAIN_MAX - GAIN_MIN + 1);
    localparam int STEP_W  = $clog2(STEPS);
    localparam int DEC_W   = $clog2(DECADES);

    // 10^(1/200) and 1.0 in Q4.60
    localparam logic [63:0] STEP_Q60 = 64'd1166271706434696416;
    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;

    typedef logic [DECADES-1:0][STEPS-1:0][FACTOR_W-1:0] factor_rom_t;

    // Linear gain factors, row = decade, column = 0.1 dB step in the decade.
    // Evaluated at elaboration only.
    function automatic factor_rom_t build_factor_rom();
        factor_rom_t  rom;
        logic [63:0]  v;
        logic [127:0] prod;
        logic [63:0]  num;
        logic [63:0]  q;
        int           r;
        int           dec;
        rom = '0;
        v   = ONE_Q60;
        for (r = 0; r < STEPS; r++) begin
            if (r != 0) begin
                prod = 128'(v) * 128'(STEP_Q60);
                prod = prod + (128'd1 << 59);
                v    = prod[123:60];
            end
            num = v >> (59 - GAIN_FRAC_BITS);
            for (dec = 0; dec < DECADES; dec++) begin
                // lowest decade is divided by 10^6, top decade by 1
                unique case (dec)
                    0:       q = (num + 64'd1000000) / 64'd2000000;
                    1:       q = (num + 64'd100000) / 64'd200000;
                    2:       q = (num + 64'd10000) / 64'd20000;
                    3:       q = (num + 64'd1000) / 64'd2000;
                    4:       q = (num + 64'd100) / 64'd200;
                    5:       q = (num + 64'd10) / 64'd20;
                    default: q = (num + 64'd1) / 64'd2;
                endcase
                rom[dec][r] = q[FACTOR_W-1:0];
            end
        end
        return rom;
    endfunction

    localparam factor_rom_t FACTOR_ROM = build_factor_rom();

endpackage

@@ hdl/stereo_db_gain_saturate.sv @@
// Channel | Dir | tdata fields (lsb first)
// s_axis  | in  | left_sample[15:0], right_sample[31:16], gain_tenths_db[43:32], pad to 48
// m_axis  | out | left_out[15:0], right_out[31:16]
//
// One frame per cycle sustained while m_tready is held high; the input register
// loads at the transfer, then gain lookup, multiply, round and clamp feed the
// result register.
// Synchronous active-low reset clears both valid flags; no table init pass.
// A stalled result holds in the output register while the input register
// still takes one more frame.
`include "stereo_db_gain_saturate_macros.svh"

module stereo_db_gain_saturate
    import sdgs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // left_sample, right_sample, gain_tenths_db, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // left_out, right_out
);

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [GAIN_W-1:0]   gain_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg;
    logic signed [SAMPLE_W-1:0] right_out_reg;

    logic                       advance;
    logic                       in_valid_next;
    logic                       out_valid_next;
    logic        [FACTOR_W-1:0] factor;
    logic signed [SAMPLE_W-1:0] left_scaled;
    logic signed [SAMPLE_W-1:0] right_scaled;

    // Pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            left_reg  <= s_tdata[SAMPLE_W-1:0];
            right_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            gain_reg  <= s_tdata[2*SAMPLE_W+GAIN_W-1:2*SAMPLE_W];
        end
    end

    // Gain to linear factor, shared by both channels
    sdgs_gain_lut u_gain_lut (
        .gain_tenths_db (gain_reg),
        .factor         (factor)
    );

    sdgs_scale_sat u_scale_left (
        .sample (left_reg),
        .factor (factor),
        .result (left_scaled)
    );

    sdgs_scale_sat u_scale_right (
        .sample (right_reg),
        .factor (factor),
        .result (right_scaled)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            left_out_reg  <= left_scaled;
            right_out_reg <= right_scaled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_out_reg, left_out_reg};

    // Checks
    `SDGS_ASSERT_NEXT(a_fill_out, aclk, aresetn, in_valid_reg && advance, m_tvalid, "frame lost")
    `SDGS_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready, "input blocked")
    `SDGS_ASSERT_NOW(a_no_overrun, aclk, aresetn, in_valid_reg && !advance, !s_tready, "overrun")

endmodule

@@ hdl/sdgs_gain_lut.sv @@
module sdgs_gain_lut
    import sdgs_pkg::*;
(
    input  logic signed [GAIN_W-1:0]   gain_tenths_db,
    output logic        [FACTOR_W-1:0] factor
);

    localparam int CALC_W = GAIN_W + 1;

    logic signed [CALC_W-1:0]   gain_clamped;
    logic signed [CALC_W-1:0]   idx_full;
    logic        [IDX_W-1:0]    idx;
    logic        [DEC_W-1:0]    decade;
    logic        [IDX_W-1:0]    step_full;
    logic        [STEP_W-1:0]   step;
    logic        [FACTOR_W-1:0] row_factor [DECADES];

    // Saturate the gain to the table range and rebase to zero
    always_comb begin
        priority if (gain_tenths_db < GAIN_W'(GAIN_MIN)) begin
            gain_clamped = CALC_W'(GAIN_MIN);
        end else if (gain_tenths_db > GAIN_W'(GAIN_MAX)) begin
            gain_clamped = CALC_W'(GAIN_MAX);
        end else begin
            gain_clamped = CALC_W'(gain_tenths_db);
        end
        idx_full = gain_clamped - CALC_W'(GAIN_MIN);
        idx      = idx_full[IDX_W-1:0];
    end

    // Split the index into decade and step: parallel threshold compares
    always_comb begin
        decade = '0;
        for (int k = 1; k < DECADES; k++) begin
            if (idx >= IDX_W'(k * STEPS)) begin
                decade = DEC_W'(k);
            end
        end
        step_full = idx - (IDX_W'(decade) * IDX_W'(STEPS));
        step      = step_full[STEP_W-1:0];
    end

    // One read per decade row, then pick the row
    always_comb begin
        for (int k = 0; k < DECADES; k++) begin
            row_factor[k] = FACTOR_ROM[k][step];
        end
        factor = row_factor[decade];
    end

endmodule

@@ hdl/sdgs_scale_sat.sv @@
module sdgs_scale_sat
    import sdgs_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic        [FACTOR_W-1:0] factor,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int PROD_W = SAMPLE_W + FACTOR_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int Q_W    = RND_W - GAIN_FRAC_BITS;

    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (SAMPLE_W - 1);
    localparam logic [Q_W-1:0] POS_LIM = NEG_LIM - Q_W'(1);
    localparam logic [RND_W-1:0] HALF  = RND_W'(1) << (GAIN_FRAC_BITS - 1);

    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [PROD_W-1:0]   prod;
    logic [RND_W-1:0]    rnd;
    logic [Q_W-1:0]      q;
    logic [Q_W-1:0]      q_sat;
    logic [Q_W-1:0]      q_neg;

    // Magnitude times factor, round half away from zero on the magnitude
    always_comb begin
        neg  = sample[SAMPLE_W-1];
        mag  = neg ? (~sample + SAMPLE_W'(1)) : sample;
        prod = PROD_W'(mag) * PROD_W'(factor);
        rnd  = RND_W'(prod) + HALF;
        q    = rnd[RND_W-1:GAIN_FRAC_BITS];
    end

    // Clamp to the signed sample range and restore the sign
    always_comb begin
        if (neg) begin
            q_sat = (q > NEG_LIM) ? NEG_LIM : q;
        end else begin
            q_sat = (q > POS_LIM) ? POS_LIM : q;
        end
        q_neg  = ~q_sat + Q_W'(1);
        result = neg ? q_neg[SAMPLE_W-1:0] : q_sat[SAMPLE_W-1:0];
    end

endmodule
